// ===== hw/rtl/rmcs_pkg.sv =====
// Shared types, codes and constants of the remote motor command supervisor.
// No dependencies; every other file of the block imports this package.
package rmcs_pkg;

	// Default sizing of the peer table
	localparam int MAX_PEERS_DEF = 8;
	localparam int AGE_WIDTH_DEF = 16;

	// Fixed payload widths
	localparam int ID_W    = 8;
	localparam int CODE_W  = 4;
	localparam int ARG_W   = 8;
	localparam int LEVEL_W = 3;
	localparam int LIM_W   = 16;
	localparam int HOLD_W  = 16;

	// Reset values of the limit registers and the hold counter ceiling
	localparam logic [LIM_W-1:0]  HEART_LIMIT_RST = 16'd1000;
	localparam logic [LIM_W-1:0]  HOLD_LIMIT_RST  = 16'd200;
	localparam logic [HOLD_W-1:0] HOLD_MAX        = 16'hFFFF;

	// Configuration register indexes
	localparam int CFG_IDX_W = 2;
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_RUN_ENABLE  = 2'd0,
		REG_HEART_LIMIT = 2'd1,
		REG_HOLD_LIMIT  = 2'd2
	} cfg_reg_e;

	// Request kinds
	localparam logic REQ_TICK = 1'b0;
	localparam logic REQ_CMD  = 1'b1;

	// Command codes
	typedef enum logic [CODE_W-1:0] {
		CMD_HEARTBEAT  = 4'd0,
		CMD_LEFT       = 4'd1,
		CMD_RIGHT      = 4'd2,
		CMD_STEER_STOP = 4'd3,
		CMD_START      = 4'd4,
		CMD_RETREAT    = 4'd5,
		CMD_STOP       = 4'd6,
		CMD_SPEED      = 4'd7,
		CMD_INCH       = 4'd8,
		CMD_LINK       = 4'd9,
		CMD_CONNECT    = 4'd10
	} cmd_e;

	// Steering drive codes
	localparam logic [1:0] STEER_BRAKE = 2'd0;
	localparam logic [1:0] STEER_LEFT  = 2'd1;
	localparam logic [1:0] STEER_RIGHT = 2'd2;

	// Link status codes
	localparam logic [1:0] LINK_INIT = 2'd0;
	localparam logic [1:0] LINK_CONN = 2'd1;
	localparam logic [1:0] LINK_LOST = 2'd2;

	// Control modes
	localparam logic MODE_INCH = 1'b0;
	localparam logic MODE_LINK = 1'b1;

	// Sequencer states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SWEEP,
		ST_COMMIT
	} state_t;

	// Token handed from cell to cell during a sweep
	typedef struct packed {
		logic vld;    // token present
		logic found;  // sender matched an earlier cell
		logic lost;   // an earlier cell timed out on this tick
	} tok_t;

	// Item operation broadcast to every cell for the whole sweep
	typedef struct packed {
		logic             is_tick;
		logic             aging;       // link connected: heartbeats age
		logic             refresh;     // command that refreshes the heartbeat
		logic             connect;     // accepted connect command
		logic [ID_W-1:0]  dev_id;
		logic [LIM_W-1:0] heart_limit;
	} op_t;

endpackage

// ===== hw/rtl/rmcs_if.sv =====
// Handshake channels of the supervisor: request items in, result items out.
// Depends on rmcs_pkg for the payload widths.
interface rmcs_req_if;
	import rmcs_pkg::*;

	logic              valid;
	logic              ready;
	logic              req_type;
	logic [CODE_W-1:0] cmd_code;
	logic [ID_W-1:0]   dev_id;
	logic [ARG_W-1:0]  speed_arg;

	modport source (output valid, req_type, cmd_code, dev_id, speed_arg, input ready);
	modport sink   (input valid, req_type, cmd_code, dev_id, speed_arg, output ready);
endinterface

interface rmcs_res_if;
	import rmcs_pkg::*;

	logic               valid;
	logic               ready;
	logic               motor_on;
	logic [LEVEL_W-1:0] speed_level;
	logic [1:0]         steer_drive;
	logic [1:0]         link_state;
	logic               mode_now;
	logic               ack_valid;
	logic [ID_W-1:0]    ack_target;

	modport source (output valid, motor_on, speed_level, steer_drive, link_state,
		mode_now, ack_valid, ack_target, input ready);
	modport sink   (input valid, motor_on, speed_level, steer_drive, link_state,
		mode_now, ack_valid, ack_target, output ready);
endinterface

// ===== hw/rtl/rmcs_cell.sv =====
// One peer table cell: holds a device id and its heartbeat age, and passes
// the sweep token to its neighbour in the next cycle. Depends on rmcs_pkg.
module rmcs_cell #(
	parameter int AGE_WIDTH = rmcs_pkg::AGE_WIDTH_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  rmcs_pkg::op_t  op,
	input  logic           active,     // entry lies below the fill count
	input  logic           next_slot,  // entry is the first free one
	input  rmcs_pkg::tok_t tok_in,
	output rmcs_pkg::tok_t tok_out
);
	import rmcs_pkg::*;

	localparam int CMP_W = (AGE_WIDTH > LIM_W) ? AGE_WIDTH : LIM_W;

	logic [ID_W-1:0]      id_q;
	logic [AGE_WIDTH-1:0] age_q;
	logic [AGE_WIDTH-1:0] age_inc;
	logic                 match;
	logic                 ages;
	logic                 timeout;
	tok_t                 tok_q;
	tok_t                 tok_d;

	// Compare sender, age with saturation, test against the limit
	always_comb begin
		match   = active && (id_q == op.dev_id);
		ages    = op.is_tick && op.aging && active && !tok_in.lost;
		age_inc = (age_q == {AGE_WIDTH{1'b1}}) ? age_q : age_q + AGE_WIDTH'(1);
		timeout = CMP_W'(age_inc) > CMP_W'(op.heart_limit);
	end

	// Build the outgoing token
	always_comb begin
		tok_d       = tok_in;
		tok_d.found = tok_in.found || match;
		tok_d.lost  = tok_in.lost || (ages && timeout);
	end

	// Update the entry as the token passes
	always_ff @(posedge clk) begin
		if (tok_in.vld) begin
			if (ages) begin
				age_q <= age_inc;
			end else if (!op.is_tick && op.refresh && match) begin
				age_q <= AGE_WIDTH'(1);
			end else if (!op.is_tick && op.connect && next_slot && !tok_in.found) begin
				id_q  <= op.dev_id;
				age_q <= AGE_WIDTH'(1);
			end
		end
	end

	// Hand the token on
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= '0;
		end else begin
			tok_q <= tok_in.vld ? tok_d : '0;
		end
	end

	assign tok_out = tok_q;

endmodule

// ===== hw/rtl/rmcs_ctrl.sv =====
// Sequencer and global state of the supervisor: takes items, starts the sweep,
// applies the item at its end and holds the result register. Uses rmcs_pkg.
module rmcs_ctrl #(
	parameter int MAX_PEERS = rmcs_pkg::MAX_PEERS_DEF,
	localparam int CNT_W    = $clog2(MAX_PEERS + 1)
) (
	input  logic                              clk,
	input  logic                              arst_n,
	rmcs_req_if.sink                          req,
	rmcs_res_if.source                        res,
	input  logic                              cfg_wr_en,
	input  logic [rmcs_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [rmcs_pkg::LIM_W-1:0]        cfg_wdata,
	output rmcs_pkg::op_t                     op,
	output rmcs_pkg::tok_t                    tok_first,
	input  rmcs_pkg::tok_t                    tok_last,
	output logic [CNT_W-1:0]                  peer_count
);
	import rmcs_pkg::*;

	state_t state_q, state_d;

	// Configuration registers
	logic             run_en_q;
	logic [LIM_W-1:0] heart_lim_q;
	logic [LIM_W-1:0] hold_lim_q;

	// Current item
	logic              type_q;
	logic [CODE_W-1:0] code_q;
	logic [ID_W-1:0]   id_q;
	logic [ARG_W-1:0]  arg_q;
	logic              start_q;
	logic              found_q;
	logic              lost_q;

	// Global state
	logic [CNT_W-1:0]   count_q, count_d;
	logic [1:0]         link_q, link_d;
	logic               mode_q, mode_d;
	logic               motor_q, motor_d;
	logic [LEVEL_W-1:0] level_q, level_d;
	logic [1:0]         steer_q, steer_d;
	logic [HOLD_W-1:0]  hold_q, hold_d;
	logic               ack_d;

	// Result register
	logic               out_vld_q;
	logic               ack_q;
	logic [ID_W-1:0]    ack_to_q;

	logic accept;
	logic slot_free;
	logic commit_en;
	logic in_ready;
	logic is_cmd;
	logic arg_ok;
	logic room;

	assign accept    = req.valid && in_ready;
	assign slot_free = !out_vld_q || res.ready;
	assign is_cmd    = (type_q == REQ_CMD) && run_en_q;
	assign arg_ok    = (arg_q[ARG_W-1:LEVEL_W] == '0);
	assign room      = count_q < CNT_W'(MAX_PEERS);

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:   if (accept) state_d = ST_SWEEP;
			ST_SWEEP:  if (tok_last.vld) state_d = ST_COMMIT;
			ST_COMMIT: if (slot_free) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	// State outputs
	always_comb begin
		in_ready  = 1'b0;
		commit_en = 1'b0;
		unique case (state_q)
			ST_IDLE:   in_ready = 1'b1;
			ST_SWEEP:  ;
			ST_COMMIT: commit_en = slot_free;
			default:   ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_en_q    <= 1'b0;
			heart_lim_q <= HEART_LIMIT_RST;
			hold_lim_q  <= HOLD_LIMIT_RST;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_RUN_ENABLE:  run_en_q    <= cfg_wdata[0];
				REG_HEART_LIMIT: heart_lim_q <= cfg_wdata;
				REG_HOLD_LIMIT:  hold_lim_q  <= cfg_wdata;
				default:         ;
			endcase
		end
	end

	// Capture the item on transfer
	always_ff @(posedge clk) begin
		if (accept) begin
			type_q <= req.req_type;
			code_q <= req.cmd_code;
			id_q   <= req.dev_id;
			arg_q  <= req.speed_arg;
		end
		if (tok_last.vld) begin
			found_q <= tok_last.found;
			lost_q  <= tok_last.lost;
		end
	end

	// Launch the token into the first cell
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q <= 1'b0;
		end else begin
			start_q <= accept;
		end
	end

	// Broadcast the operation to the cells
	always_comb begin
		op.is_tick     = (type_q == REQ_TICK);
		op.aging       = (link_q == LINK_CONN);
		op.dev_id      = id_q;
		op.heart_limit = heart_lim_q;
		op.connect     = is_cmd && (code_q == CMD_CONNECT);
		case (code_q) inside
			CMD_HEARTBEAT, CMD_LEFT, CMD_RIGHT, CMD_STEER_STOP, CMD_INCH, CMD_LINK:
				op.refresh = is_cmd;
			default:
				op.refresh = 1'b0;
		endcase
		tok_first       = '0;
		tok_first.vld   = start_q;
	end

	// Apply the item to the global state
	always_comb begin
		count_d = count_q;
		link_d  = link_q;
		mode_d  = mode_q;
		motor_d = motor_q;
		level_d = level_q;
		steer_d = steer_q;
		hold_d  = hold_q;
		ack_d   = 1'b0;
		if (type_q == REQ_TICK) begin
			if (hold_q != '0 && hold_q != HOLD_MAX) begin
				hold_d = hold_q + HOLD_W'(1);
			end
			if (lost_q) begin
				link_d = LINK_LOST;
			end
		end else if (run_en_q) begin
			if (found_q) begin
				unique case (code_q)
					CMD_LEFT:       steer_d = STEER_LEFT;
					CMD_RIGHT:      steer_d = STEER_RIGHT;
					CMD_STEER_STOP: steer_d = STEER_BRAKE;
					CMD_START: begin
						if (mode_q == MODE_INCH && motor_q) begin
							hold_d = HOLD_W'(1);
						end else begin
							if (arg_ok) level_d = arg_q[LEVEL_W-1:0];
							motor_d = 1'b1;
						end
					end
					CMD_STOP: begin
						if (mode_q == MODE_INCH) hold_d = '0;
						motor_d = 1'b0;
					end
					CMD_SPEED: if (arg_ok) level_d = arg_q[LEVEL_W-1:0];
					CMD_INCH: begin
						mode_d = MODE_INCH;
						hold_d = '0;
					end
					CMD_LINK: begin
						mode_d = MODE_LINK;
						hold_d = '0;
					end
					default: ;
				endcase
			end else if (code_q == CMD_CONNECT && room) begin
				count_d = count_q + CNT_W'(1);
				link_d  = LINK_CONN;
				ack_d   = 1'b1;
			end
			// Inch hold timeout stops the motor
			if (hold_d > hold_lim_q) begin
				motor_d = 1'b0;
			end
		end
	end

	// Global state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			link_q  <= LINK_INIT;
			mode_q  <= MODE_INCH;
			motor_q <= 1'b0;
			level_q <= '0;
			steer_q <= STEER_BRAKE;
			hold_q  <= '0;
		end else if (commit_en) begin
			count_q <= count_d;
			link_q  <= link_d;
			mode_q  <= mode_d;
			motor_q <= motor_d;
			level_q <= level_d;
			steer_q <= steer_d;
			hold_q  <= hold_d;
		end
	end

	// Result register: load on commit, drop on transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (commit_en) begin
			out_vld_q <= 1'b1;
		end else if (res.ready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (commit_en) begin
			ack_q    <= ack_d;
			ack_to_q <= ack_d ? id_q : '0;
		end
	end

	assign req.ready       = in_ready;
	assign res.valid       = out_vld_q;
	assign res.motor_on    = motor_q;
	assign res.speed_level = level_q;
	assign res.steer_drive = steer_q;
	assign res.link_state  = link_q;
	assign res.mode_now    = mode_q;
	assign res.ack_valid   = ack_q;
	assign res.ack_target  = ack_to_q;
	assign peer_count      = count_q;

`ifndef ASSERT_OFF
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(MAX_PEERS))
		else $error("peer count beyond table size");

	a_token_in_sweep: assert property (@(posedge clk) disable iff (!arst_n)
		tok_last.vld |-> state_q == ST_SWEEP)
		else $error("token left the chain outside a sweep");

	a_ack_target_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(out_vld_q && !ack_q) |-> ack_to_q == '0)
		else $error("acknowledge target set without acknowledge");

	a_connect_links: assert property (@(posedge clk) disable iff (!arst_n)
		(commit_en && ack_d) |=> link_q == LINK_CONN)
		else $error("connect did not establish the link");
`endif

endmodule

// ===== hw/rtl/remote_motor_command_supervisor.sv =====
// Top level of the remote motor command supervisor: the sequencer plus a row
// of peer table cells. Depends on rmcs_pkg, rmcs_if, rmcs_cell and rmcs_ctrl.
//
// Usage:
//  - req carries ticks (req_type 0) and received commands (req_type 1); res
//    returns exactly one result per request, the state after that request.
//  - cfg_wr_en/cfg_index/cfg_wdata write run_enable (0), heart_limit (1) and
//    hold_limit (2); write only while no request is in flight.
//  - One request at a time: after a transfer on req, a token walks the cell
//    row one cell per cycle, then the commit state loads the result register;
//    req.ready rises at the same edge, so a new request is taken only after
//    the result of the last one is loaded.
//  - The result sits in an output register; a stalled receiver holds it and
//    the next request is still taken and swept, waiting at commit until the
//    register is free.
//  - Reset empties the peer table (fill count zero), sets the link to initial,
//    inch mode, motor off, level zero, steering brake, hold count zero and the
//    registers to 0, 1000 and 200.
module remote_motor_command_supervisor #(
	parameter int MAX_PEERS = rmcs_pkg::MAX_PEERS_DEF,
	parameter int AGE_WIDTH = rmcs_pkg::AGE_WIDTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	rmcs_req_if.sink                       req,
	rmcs_res_if.source                     res,
	input  logic                           cfg_wr_en,
	input  logic [rmcs_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [rmcs_pkg::LIM_W-1:0]     cfg_wdata
);
	import rmcs_pkg::*;

	localparam int CNT_W = $clog2(MAX_PEERS + 1);

	op_t              op;
	tok_t             tok [MAX_PEERS+1];
	logic [CNT_W-1:0] peer_count;

	rmcs_ctrl #(
		.MAX_PEERS (MAX_PEERS)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (req),
		.res        (res),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_index  (cfg_index),
		.cfg_wdata  (cfg_wdata),
		.op         (op),
		.tok_first  (tok[0]),
		.tok_last   (tok[MAX_PEERS]),
		.peer_count (peer_count)
	);

	// Row of table cells, token passed left to right
	for (genvar i = 0; i < MAX_PEERS; i++) begin : g_cell
		logic active;
		logic next_slot;

		// Mark filled entries and the first free one
		assign active    = peer_count > CNT_W'(i);
		assign next_slot = peer_count == CNT_W'(i);

		rmcs_cell #(
			.AGE_WIDTH (AGE_WIDTH)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.op        (op),
			.active    (active),
			.next_slot (next_slot),
			.tok_in    (tok[i]),
			.tok_out   (tok[i+1])
		);
	end

endmodule
